// ----- rtl/core/saa_pkg.sv -----
// ----------------------------------------------------------------------------
// saa_pkg
// Shared types and constants for the sensor average alarm: field widths,
// command and status codes, register indexes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int DATA_W    = 16;
  localparam int ID_W      = 16;
  localparam int SLOT_IN_W = 4;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 1;
  localparam int TOT_W     = 3;

  // item commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 1'b1;

  // threshold reset values, Q8.8
  localparam logic signed [DATA_W-1:0] MAX_TEMP_RST = 16'sd6400;
  localparam logic signed [DATA_W-1:0] MIN_TEMP_RST = 16'sd3840;

  // warm-up: report the latest earlier reading until more than this many have arrived
  localparam logic [TOT_W-1:0] WARMUP_READINGS = 3'd5;
  localparam logic [TOT_W-1:0] TOTAL_SAT       = 3'd6;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_NORMAL  = 3'd1,
    ST_HOT     = 3'd2,
    ST_COLD    = 3'd3,
    ST_INVALID = 3'd4,
    ST_NOHIST  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_META,
    S_PLAN,
    S_LAST,
    S_LAST_WAIT,
    S_SUM,
    S_DIV,
    S_UPD,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic map_write;
    logic res_loaded;
    logic res_invalid;
    logic scan_clr;
    logic scan_step;
    logic meta_latch;
    logic sum_clr;
    logic sum_step;
    logic last_latch;
    logic div_init;
    logic div_step;
    logic div_finish;
    logic update;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic is_load;
    logic slot_ok;
    logic hit;
    logic miss;
    logic fill_zero;
    logic warm;
    logic sum_done;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/saa_ifs.sv -----
// ----------------------------------------------------------------------------
// saa_ifs
// Channel interfaces: input items, result items and configuration writes,
// each a valid/ready channel with a source and a sink side.
// ----------------------------------------------------------------------------
interface saa_in_if import saa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [SLOT_IN_W-1:0]        slot;
  logic [ID_W-1:0]             room;
  logic [ID_W-1:0]             sensor;
  logic signed [DATA_W-1:0]    reading;

  modport source (output valid, output cmd, output slot, output room, output sensor,
                  output reading, input ready);
  modport sink (input valid, input cmd, input slot, input room, input sensor,
                input reading, output ready);
endinterface

interface saa_out_if import saa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic signed [DATA_W-1:0]    average;
  logic [ID_W-1:0]             room_out;
  logic [ID_W-1:0]             sensor_out;

  modport source (output valid, output status, output average, output room_out,
                  output sensor_out, input ready);
  modport sink (input valid, input status, input average, input room_out,
                input sensor_out, output ready);
endinterface

interface saa_cfg_if import saa_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [CFG_IDX_W-1:0]        index;
  logic [DATA_W-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/saa_ram.sv -----
// ----------------------------------------------------------------------------
// saa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module saa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/saa_ctrl.sv -----
// ----------------------------------------------------------------------------
// saa_ctrl
// Controller: sequences one word through decode, map scan, history read,
// bit-serial divide, update and result hand-off.
// ----------------------------------------------------------------------------
module saa_ctrl import saa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (sts.in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = sts.is_load ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = S_META;
        end else if (sts.miss) begin
          state_nxt = S_DONE;
        end
      end
      S_META: state_nxt = S_PLAN;
      S_PLAN: begin
        if (sts.fill_zero) begin
          state_nxt = S_UPD;
        end else if (sts.warm) begin
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_SUM;
        end
      end
      S_LAST:      state_nxt = S_LAST_WAIT;
      S_LAST_WAIT: state_nxt = S_UPD;
      S_SUM: begin
        if (sts.sum_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_UPD;
      end
      S_UPD: state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.in_ready = 1'b1;
      S_DECODE: begin
        if (sts.is_load) begin
          if (sts.slot_ok) begin
            cmd.map_write  = 1'b1;
            cmd.res_loaded = 1'b1;
          end else begin
            cmd.res_invalid = 1'b1;
          end
        end else begin
          cmd.scan_clr = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.miss) cmd.res_invalid = 1'b1;
      end
      S_META: ;
      S_PLAN: begin
        cmd.meta_latch = 1'b1;
        cmd.sum_clr    = 1'b1;
      end
      S_LAST: ;
      S_LAST_WAIT: cmd.last_latch = 1'b1;
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_done) cmd.div_init = 1'b1;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_finish = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_UPD: cmd.update = 1'b1;
      S_DONE: begin
        if (sts.out_free) cmd.out_load = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/core/saa_dp.sv -----
// ----------------------------------------------------------------------------
// saa_dp
// Datapath: captured word, threshold registers, sensor map and history
// memories, scan and sum counters, restoring divider and result registers.
// ----------------------------------------------------------------------------
module saa_dp import saa_pkg::*; #(
  parameter int MAP_SLOTS   = 16,
  parameter int HISTORY_LEN = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_sts_t    sts,
  saa_in_if.sink     in_if,
  saa_out_if.source  out_if,
  saa_cfg_if.sink    cfg_if
);

  localparam int SLOT_W     = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
  localparam int SCAN_W     = $clog2(MAP_SLOTS + 1);
  localparam int IDX_W      = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
  localparam int FILL_W     = $clog2(HISTORY_LEN + 1);
  localparam int META_W     = FILL_W + IDX_W;
  localparam int HIST_DEPTH = MAP_SLOTS * HISTORY_LEN;
  localparam int HADDR_W    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SUM_W      = DATA_W + IDX_W;
  localparam int DCNT_W     = $clog2(SUM_W + 1);

  // captured word
  logic                     cmd_in_r;
  logic [SLOT_IN_W-1:0]     slot_in_r;
  logic [ID_W-1:0]          room_in_r;
  logic [ID_W-1:0]          sensor_r;
  logic signed [DATA_W-1:0] reading_r;

  // thresholds
  logic signed [DATA_W-1:0] max_temp_r;
  logic signed [DATA_W-1:0] min_temp_r;

  // map and scan
  logic [MAP_SLOTS-1:0]     vld_r;
  logic [SCAN_W-1:0]        scan_r;
  logic [SLOT_W-1:0]        chk_r;
  logic                     chk_v_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        load_addr;
  logic                     scan_issue;
  logic                     hit;

  // per-slot history bookkeeping
  logic [HADDR_W-1:0]       base_r;
  logic [FILL_W-1:0]        fill_r;
  logic [IDX_W-1:0]         next_r;
  logic [ID_W-1:0]          room_r;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         next_new;
  logic [FILL_W-1:0]        fill_new;
  logic [TOT_W-1:0]         total_r;

  // summation
  logic [FILL_W-1:0]        hidx_r;
  logic [FILL_W-1:0]        cons_r;
  logic                     rd_v_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic                     sum_issue;

  // divider
  logic [SUM_W-1:0]         quo_r;
  logic [FILL_W-1:0]        rem_r;
  logic                     neg_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic [FILL_W:0]          rem_sh;
  logic                     div_ge;
  logic [DATA_W-1:0]        quo_mag;
  logic signed [DATA_W-1:0] ref_r;

  // result staging and output register
  status_t                  res_status_r;
  logic signed [DATA_W-1:0] res_avg_r;
  logic [ID_W-1:0]          res_room_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_avg_r;
  logic [ID_W-1:0]          out_room_r;
  logic [ID_W-1:0]          out_sensor_r;

  // memory ports
  logic [ID_W-1:0]          id_rd;
  logic [ID_W-1:0]          room_rd;
  logic [META_W-1:0]        meta_rd;
  logic                     meta_we;
  logic [SLOT_W-1:0]        meta_waddr;
  logic [META_W-1:0]        meta_wdata;
  logic signed [DATA_W-1:0] hist_rd;
  logic [HADDR_W-1:0]       hist_raddr;
  logic [HADDR_W-1:0]       hist_waddr;

  assign in_if.ready  = cmd.in_ready;
  assign cfg_if.ready = 1'b1;

  // capture the input word
  always_ff @(posedge clk) begin
    if (in_if.valid && cmd.in_ready) begin
      cmd_in_r  <= in_if.cmd;
      slot_in_r <= in_if.slot;
      room_in_r <= in_if.room;
      sensor_r  <= in_if.sensor;
      reading_r <= in_if.reading;
    end
  end

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_temp_r <= MAX_TEMP_RST;
      min_temp_r <= MIN_TEMP_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_MAX_TEMP: max_temp_r <= cfg_if.data;
        CFG_MIN_TEMP: min_temp_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign load_addr = SLOT_W'(slot_in_r);

  // slot valid bits, set by a load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.map_write) begin
      vld_r[load_addr] <= 1'b1;
    end
  end

  // serial map scan: issue address, compare in the next cycle
  assign scan_issue = scan_r < SCAN_W'(MAP_SLOTS);
  assign hit        = chk_v_r && vld_r[chk_r] && (id_rd == sensor_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      scan_r  <= '0;
      chk_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_v_r <= scan_issue;
      chk_r   <= scan_r[SLOT_W-1:0];
      if (scan_issue) scan_r <= scan_r + SCAN_W'(1);
      if (hit) slot_r <= chk_r;
    end
  end

  // row base of the matched slot in the history memory
  always_ff @(posedge clk) begin
    base_r <= HADDR_W'(slot_r) * HADDR_W'(HISTORY_LEN);
  end

  // latch fill, write pointer and room of the matched slot
  always_ff @(posedge clk) begin
    if (cmd.meta_latch) begin
      fill_r <= meta_rd[META_W-1 -: FILL_W];
      next_r <= meta_rd[IDX_W-1:0];
      room_r <= room_rd;
    end
  end

  assign last_idx = (next_r == '0) ? IDX_W'(HISTORY_LEN - 1) : next_r - IDX_W'(1);
  assign next_new = (next_r == IDX_W'(HISTORY_LEN - 1)) ? '0 : next_r + IDX_W'(1);
  assign fill_new = (fill_r < FILL_W'(HISTORY_LEN)) ? fill_r + FILL_W'(1) : fill_r;

  // accumulate the stored readings one per cycle
  assign sum_issue = hidx_r < fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (cmd.sum_clr) begin
      hidx_r <= '0;
      cons_r <= '0;
      rd_v_r <= 1'b0;
      acc_r  <= '0;
    end else if (cmd.sum_step) begin
      rd_v_r <= sum_issue;
      if (sum_issue) hidx_r <= hidx_r + FILL_W'(1);
      if (rd_v_r) begin
        acc_r  <= acc_r + SUM_W'(hist_rd);
        cons_r <= cons_r + FILL_W'(1);
      end
    end
  end

  // restoring divide of |sum| by fill, one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, fill_r};
  assign quo_mag = quo_r[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r  <= acc_r[SUM_W-1];
      quo_r  <= acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
      rem_r  <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? FILL_W'(rem_sh - {1'b0, fill_r}) : rem_sh[FILL_W-1:0];
      quo_r  <= {quo_r[SUM_W-2:0], div_ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  // reference value: latest reading or truncated average
  always_ff @(posedge clk) begin
    if (cmd.last_latch) begin
      ref_r <= hist_rd;
    end else if (cmd.div_finish) begin
      ref_r <= neg_r ? -quo_mag : quo_mag;
    end
  end

  // readings counter, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.update && (total_r < TOTAL_SAT)) begin
      total_r <= total_r + TOT_W'(1);
    end
  end

  // stage the result
  always_ff @(posedge clk) begin
    if (cmd.res_loaded) begin
      res_status_r <= ST_LOADED;
      res_avg_r    <= '0;
      res_room_r   <= room_in_r;
    end else if (cmd.res_invalid) begin
      res_status_r <= ST_INVALID;
      res_avg_r    <= '0;
      res_room_r   <= '0;
    end else if (cmd.update) begin
      res_room_r <= room_r;
      if (fill_r == '0) begin
        res_status_r <= ST_NOHIST;
        res_avg_r    <= '0;
      end else begin
        res_avg_r <= ref_r;
        if (ref_r > max_temp_r) begin
          res_status_r <= ST_HOT;
        end else if (ref_r < min_temp_r) begin
          res_status_r <= ST_COLD;
        end else begin
          res_status_r <= ST_NORMAL;
        end
      end
    end
  end

  // output register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_avg_r    <= res_avg_r;
      out_room_r   <= res_room_r;
      out_sensor_r <= sensor_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.average    = out_avg_r;
  assign out_if.room_out   = out_room_r;
  assign out_if.sensor_out = out_sensor_r;

  // memories
  assign meta_we    = cmd.map_write || cmd.update;
  assign meta_waddr = cmd.update ? slot_r : load_addr;
  assign meta_wdata = cmd.update ? {fill_new, next_new} : '0;
  assign hist_waddr = base_r + HADDR_W'(next_r);
  assign hist_raddr = base_r + (cmd.sum_step ? HADDR_W'(hidx_r) : HADDR_W'(last_idx));

  saa_ram #(.WIDTH(ID_W), .DEPTH(MAP_SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (cmd.map_write),
    .waddr (load_addr),
    .wdata (sensor_r),
    .raddr (scan_r[SLOT_W-1:0]),
    .rdata (id_rd)
  );

  saa_ram #(.WIDTH(ID_W), .DEPTH(MAP_SLOTS)) u_room_ram (
    .clk   (clk),
    .we    (cmd.map_write),
    .waddr (load_addr),
    .wdata (room_in_r),
    .raddr (slot_r),
    .rdata (room_rd)
  );

  saa_ram #(.WIDTH(META_W), .DEPTH(MAP_SLOTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (slot_r),
    .rdata (meta_rd)
  );

  saa_ram #(.WIDTH(DATA_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (hist_waddr),
    .wdata (reading_r),
    .raddr (hist_raddr),
    .rdata (hist_rd)
  );

  // status back to the controller
  always_comb begin
    sts.in_valid  = in_if.valid;
    sts.is_load   = (cmd_in_r == CMD_LOAD);
    sts.slot_ok   = int'(slot_in_r) < MAP_SLOTS;
    sts.hit       = hit;
    sts.miss      = chk_v_r && !hit && (chk_r == SLOT_W'(MAP_SLOTS - 1));
    sts.fill_zero = (meta_rd[META_W-1 -: FILL_W] == '0);
    sts.warm      = (total_r <= WARMUP_READINGS);
    sts.sum_done  = (cons_r == fill_r);
    sts.div_done  = (dcnt_r == DCNT_W'(SUM_W));
    sts.out_free  = !out_valid_r || out_if.ready;
  end

endmodule

// ----- rtl/core/sensor_average_alarm.sv -----
// ----------------------------------------------------------------------------
// sensor_average_alarm
// Per-sensor moving-average threshold monitor with a loadable sensor map.
// ----------------------------------------------------------------------------
// Channels: in_if takes words (cmd 0 loads a map slot with sensor and room
// and clears its history; cmd 1 is a temperature reading). out_if returns
// one word per input word: status, average, room_out, sensor_out. cfg_if
// writes max_temp (index 0) and min_temp (index 1) and is always ready;
// write it only while the block is idle.
// Flow: a load is decoded and its result handed off. A reading scans
// the map one slot per cycle; an unknown id ends the scan at the last slot.
// A known id reads its slot's fill and write pointer; with no history it
// reports no history, in warm-up it reads the latest reading, else it sums
// the stored readings and runs a bit-serial divide. The map scan and the
// divider set the rate; one word is in work at a time.
// Reset clears the slot valid bits, the readings counter, the thresholds
// to 25.0 and 15.0 degrees, and the output valid; no memory clearing pass.
// A stalled receiver holds the result in the output register; the next
// word is still accepted and is held at its end until the register frees.
// ----------------------------------------------------------------------------
module sensor_average_alarm import saa_pkg::*; #(
  parameter int MAP_SLOTS   = 16,
  parameter int HISTORY_LEN = 5
) (
  input  logic      clk,
  input  logic      rst_n,
  saa_in_if.sink    in_if,
  saa_out_if.source out_if,
  saa_cfg_if.sink   cfg_if
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  saa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (dp_sts),
    .cmd   (ctrl_cmd)
  );

  saa_dp #(
    .MAP_SLOTS   (MAP_SLOTS),
    .HISTORY_LEN (HISTORY_LEN)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (ctrl_cmd),
    .sts    (dp_sts),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

`ifndef ASSERT_OFF
  // one word in work at a time
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input accepted again while a word is in work");

  // never overwrite a result the receiver has not taken
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.out_load |-> (!out_if.valid || out_if.ready))
    else $error("output register loaded while stalled");

  // one result source per word
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl_cmd.res_loaded, ctrl_cmd.res_invalid, ctrl_cmd.update}))
    else $error("more than one result staged at once");

  // map written only by a load to an existing slot
  a_map_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_cmd.map_write |-> (dp_sts.is_load && dp_sts.slot_ok))
    else $error("map written by a word that is no legal load");
`endif

endmodule
